### hw/rtl/wan_pkg.sv
// Shared types and constants of the weekly alarm next-ring block.
package wan_pkg;

    localparam int unsigned DAY_SECONDS    = 86400;
    localparam int unsigned WEEK_SECONDS   = 604800;
    localparam int unsigned MINUTE_SECONDS = 60;
    localparam logic [7:0]  ENABLE_BIT     = 8'h01;

    localparam logic [11:0] RING_LENGTH_RESET = 12'd60;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] CFG_DAY_ORIGIN  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RING_LENGTH = 8'd1;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    // Top shift of the week and day reduction passes
    localparam logic [3:0] FOLD_SHIFT_TOP = 4'd13;
    localparam logic [3:0] DAY_SHIFT_TOP  = 4'd2;

    localparam logic [2:0] SLOT_ONESHOT = 3'd0;
    localparam logic [2:0] SLOT_LAST    = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_DAYMOD,
        ST_SEARCH,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic       wr_entry;
        logic       load;
        logic       fold_step;
        logic       day_step;
        logic       search_step;
        logic       finish;
        logic [3:0] shift;
        logic [2:0] slot;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

### hw/rtl/wan_ctrl.sv
// Sequencer of the next-ring search: fold, day reduction, candidate sweep, result.
module wan_ctrl #(
    parameter int unsigned ALARM_COUNT = 8,
    parameter int unsigned IW = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_cmd,
    output logic                o_in_ready,
    input  wan_pkg::t_dp_status i_status,
    output wan_pkg::t_dp_cmd    o_cmd,
    output logic [IW-1:0]       o_entry
);
    import wan_pkg::*;

    localparam logic [IW-1:0] ENTRY_LAST = IW'(ALARM_COUNT - 1);

    t_state        r_state, n_state;
    logic [3:0]    r_shift, n_shift;
    logic [2:0]    r_slot,  n_slot;
    logic [IW-1:0] r_entry, n_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_shift <= '0;
            r_slot  <= '0;
            r_entry <= '0;
        end else begin
            r_state <= n_state;
            r_shift <= n_shift;
            r_slot  <= n_slot;
            r_entry <= n_entry;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_shift    = r_shift;
        n_slot     = r_slot;
        n_entry    = r_entry;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.shift = r_shift;
        o_cmd.slot  = r_slot;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_cmd == CMD_WRITE) begin
                        o_cmd.wr_entry = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_shift    = FOLD_SHIFT_TOP;
                        n_state    = ST_FOLD;
                    end
                end
            end
            ST_FOLD: begin
                o_cmd.fold_step = 1'b1;
                if (r_shift == '0) begin
                    n_shift = DAY_SHIFT_TOP;
                    n_state = ST_DAYMOD;
                end else begin
                    n_shift = r_shift - 4'd1;
                end
            end
            ST_DAYMOD: begin
                o_cmd.day_step = 1'b1;
                if (r_shift == '0) begin
                    n_slot  = SLOT_ONESHOT;
                    n_entry = '0;
                    n_state = ST_SEARCH;
                end else begin
                    n_shift = r_shift - 4'd1;
                end
            end
            ST_SEARCH: begin
                o_cmd.search_step = 1'b1;
                if (r_slot == SLOT_LAST) begin
                    n_slot = SLOT_ONESHOT;
                    if (r_entry == ENTRY_LAST) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_entry = r_entry + 1'b1;
                    end
                end else begin
                    n_slot = r_slot + 3'd1;
                end
            end
            ST_FINISH: begin
                // hold until the output register can take the result
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_entry = r_entry;

endmodule

### hw/rtl/wan_dp.sv
// Datapath: alarm table, configuration, time fold, candidate compare and result register.
module wan_dp #(
    parameter int unsigned ALARM_COUNT = 8,
    parameter int unsigned IW = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  wan_pkg::t_dp_cmd                   i_cmd,
    input  logic [IW-1:0]                      i_entry,
    output wan_pkg::t_dp_status                o_status,
    input  logic                               i_cfg_valid,
    input  logic [wan_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [wan_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [2:0]                         i_entry_index,
    input  logic [10:0]                        i_entry_minute,
    input  logic [7:0]                         i_entry_days,
    input  logic [31:0]                        i_now_seconds,
    input  logic [19:0]                        i_pending_seconds,
    input  logic                               i_snooze_active,
    input  logic                               i_ringing,
    input  logic                               i_on_main_screen,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [19:0]                        o_next_seconds,
    output logic                               o_auto_off_valid,
    output logic [2:0]                         o_auto_off_index
);
    import wan_pkg::*;

    logic [2:0]    r_wk_ofs;
    logic [11:0]   r_ring_len;
    logic [10:0]   r_min  [ALARM_COUNT];
    logic [7:0]    r_days [ALARM_COUNT];

    logic [32:0]   r_cur;
    logic [19:0]   r_curday;
    logic [19:0]   r_pend;
    logic          r_snz, r_ring, r_main;
    logic [19:0]   r_best;
    logic          r_off_v;
    logic [IW-1:0] r_off_idx;

    logic          r_out_valid;
    logic [19:0]   r_out_secs;
    logic          r_out_off_v;
    logic [2:0]    r_out_off_idx;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wk_ofs   <= '0;
            r_ring_len <= RING_LENGTH_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_DAY_ORIGIN) begin
                r_wk_ofs <= i_cfg_data[2:0];
            end else if (i_cfg_index == CFG_RING_LENGTH) begin
                r_ring_len <= i_cfg_data;
            end
        end
    end

    // alarm table; cleared days keep every entry off after reset
    logic wr_hit;
    assign wr_hit = i_cmd.wr_entry && (int'(i_entry_index) < ALARM_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ALARM_COUNT; i++) begin
                r_days[i] <= '0;
            end
        end else if (wr_hit) begin
            r_days[IW'(i_entry_index)] <= i_entry_days;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_min[IW'(i_entry_index)] <= i_entry_minute;
        end
    end

    // fold into a second of the week, then of the day
    logic [32:0] fold_sub, fold_next;
    logic [19:0] day_sub;

    assign fold_sub  = 33'(WEEK_SECONDS) << i_cmd.shift;
    assign fold_next = (r_cur >= fold_sub) ? (r_cur - fold_sub) : r_cur;
    assign day_sub   = 20'(DAY_SECONDS) << i_cmd.shift;

    // candidate for the current slot
    logic [7:0]         days;
    logic [16:0]        mins;
    logic [2:0]         day_k;
    logic [2:0]         bit_sel;
    logic [19:0]        day_base;
    logic signed [21:0] cand_raw;
    logic [21:0]        cand_fix;
    logic [19:0]        cand;
    logic               is_oneshot;
    logic               slot_hit;
    logic               better;
    logic               take;

    always_comb begin
        days       = r_days[i_entry];
        mins       = 17'(r_min[i_entry]) * 17'(MINUTE_SECONDS);
        is_oneshot = (i_cmd.slot == SLOT_ONESHOT);
        day_k      = i_cmd.slot - 3'd1;
        bit_sel    = 3'd0 - i_cmd.slot;
        day_base   = 20'(day_k) * 20'(DAY_SECONDS);
        if (is_oneshot) begin
            cand_raw = $signed(22'(mins)) - $signed(22'(r_curday));
        end else begin
            cand_raw = $signed(22'(day_base)) + $signed(22'(mins))
                     - $signed(22'(r_cur[19:0]));
        end
        cand_fix = 22'(cand_raw);
        if (cand_raw[21] || (cand_raw == '0)) begin
            cand_fix = is_oneshot ? (22'(cand_raw) + 22'(DAY_SECONDS))
                                  : (22'(cand_raw) + 22'(WEEK_SECONDS));
        end
        cand     = cand_fix[19:0];
        slot_hit = is_oneshot ? (days == ENABLE_BIT) : days[bit_sel];
        // a one-shot wins ties, a weekly candidate must be strictly sooner
        better   = (r_best == '0) || (is_oneshot ? (cand <= r_best) : (cand < r_best));
        take     = i_cmd.search_step && days[0] && slot_hit && better;
    end

    // snooze and ring rules
    logic [19:0] snz_best;
    logic        snz_off;
    logic [19:0] ring_pend;
    logic [20:0] ring_sum;
    logic [19:0] fin_best;
    logic        fin_off;

    always_comb begin
        snz_best  = r_best;
        snz_off   = r_off_v;
        ring_pend = r_pend;
        ring_sum  = 21'(r_best) + 21'(r_ring_len);
        if (r_snz && ((r_pend < r_best) || (r_best == '0))) begin
            snz_best = r_pend;
            snz_off  = 1'b0;
        end
        ring_sum = 21'(snz_best) + 21'(r_ring_len);
        fin_best = snz_best;
        fin_off  = snz_off;
        if (r_ring) begin
            fin_off = 1'b0;
            if (r_pend == '0) begin
                ring_pend = 20'(r_ring_len);
            end
            if ((ring_pend >= snz_best) && (snz_best <= 20'(r_ring_len))
                    && (snz_best != '0)) begin
                fin_best = ring_sum[19:0];
            end else begin
                fin_best = ring_pend;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur     <= 33'(i_now_seconds) + 33'(r_wk_ofs) * 33'(DAY_SECONDS);
            r_pend    <= i_pending_seconds;
            r_snz     <= i_snooze_active;
            r_ring    <= i_ringing;
            r_main    <= i_on_main_screen;
            r_best    <= '0;
            r_off_v   <= 1'b0;
            r_off_idx <= '0;
        end else begin
            if (i_cmd.fold_step) begin
                r_cur    <= fold_next;
                r_curday <= fold_next[19:0];
            end
            if (i_cmd.day_step && (r_curday >= day_sub)) begin
                r_curday <= r_curday - day_sub;
            end
            if (take) begin
                r_best  <= cand;
                r_off_v <= is_oneshot ? r_main : 1'b0;
                if (is_oneshot) begin
                    r_off_idx <= i_entry;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_secs    <= fin_best;
            r_out_off_v   <= fin_off;
            r_out_off_idx <= fin_off ? 3'(r_off_idx) : 3'd0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_next_seconds    = r_out_secs;
    assign o_auto_off_valid  = r_out_off_v;
    assign o_auto_off_index  = r_out_off_idx;

endmodule

### hw/rtl/weekly_alarm_next_ring_top.sv
// Top level of the weekly alarm next-ring block.
// A write request (cmd 0) loads one alarm entry; writes to an entry index of
// ALARM_COUNT or more are dropped. For a compute request (cmd 1) the inputs are
// loaded at the accepting edge, then 14 steps reduce the time to a second of the
// week, 3 steps reduce it to a second of the day, eight slots per entry (the
// one-shot check and seven weekdays) go through a single shared candidate compare
// unit, and a finish step applies the snooze and ring rules as the result is
// written to the output register. The block then returns to idle before it takes
// the next request. The result sits in an output register, so the next request is
// accepted while it waits; a following compute request only holds in its finish
// step until that register is free. Configuration writes are always taken and
// should be issued only while the block is idle.
module weekly_alarm_next_ring_top #(
    parameter int unsigned ALARM_COUNT = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wan_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [wan_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_cmd,
    input  logic [2:0]                      i_entry_index,
    input  logic [10:0]                     i_entry_minute,
    input  logic [7:0]                      i_entry_days,
    input  logic [31:0]                     i_now_seconds,
    input  logic [19:0]                     i_pending_seconds,
    input  logic                            i_snooze_active,
    input  logic                            i_ringing,
    input  logic                            i_on_main_screen,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [19:0]                     o_next_seconds,
    output logic                            o_auto_off_valid,
    output logic [2:0]                      o_auto_off_index
);
    import wan_pkg::*;

    localparam int unsigned IW = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;

    t_dp_cmd       dp_cmd;
    t_dp_status    dp_status;
    logic [IW-1:0] entry_sel;

    assign o_cfg_ready = 1'b1;

    wan_ctrl #(
        .ALARM_COUNT (ALARM_COUNT),
        .IW          (IW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_entry    (entry_sel)
    );

    wan_dp #(
        .ALARM_COUNT (ALARM_COUNT),
        .IW          (IW)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .i_entry           (entry_sel),
        .o_status          (dp_status),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_entry_index     (i_entry_index),
        .i_entry_minute    (i_entry_minute),
        .i_entry_days      (i_entry_days),
        .i_now_seconds     (i_now_seconds),
        .i_pending_seconds (i_pending_seconds),
        .i_snooze_active   (i_snooze_active),
        .i_ringing         (i_ringing),
        .i_on_main_screen  (i_on_main_screen),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_next_seconds    (o_next_seconds),
        .o_auto_off_valid  (o_auto_off_valid),
        .o_auto_off_index  (o_auto_off_index)
    );

endmodule

### hw/rtl/wan_check.sv
// Port-level checks of the weekly alarm next-ring block, bound to its top level.
module wan_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_cmd,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [19:0] o_next_seconds,
    input logic        o_auto_off_valid,
    input logic [2:0]  o_auto_off_index
);
    import wan_pkg::*;

    // a compute request keeps the input side busy in the next cycle
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_cmd == CMD_COMPUTE)) |=> !o_in_ready)
        else $error("input ready right after a compute request");

    // a write request never stalls the next one
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_cmd == CMD_WRITE)) |=> o_in_ready)
        else $error("input stalled after a write request");

    // no auto-off index without auto-off
    a_off_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_auto_off_valid) |-> (o_auto_off_index == 3'd0))
        else $error("auto-off index set while auto-off is clear");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_next_seconds) && $stable(o_auto_off_valid)))
        else $error("stalled result changed");

endmodule

bind weekly_alarm_next_ring_top wan_check u_wan_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_cmd            (i_cmd),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_next_seconds   (o_next_seconds),
    .o_auto_off_valid (o_auto_off_valid),
    .o_auto_off_index (o_auto_off_index)
);

### verif/wan_ring_checker.sv
// Checker for the weekly alarm next-ring block: mirrors its table and settings, predicts each ring.
`timescale 1ns / 100ps

module wan_ring_checker #(
    parameter int unsigned ALARM_COUNT = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [wan_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [wan_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic                            i_cmd,
    input  logic [2:0]                      i_entry_index,
    input  logic [10:0]                     i_entry_minute,
    input  logic [7:0]                      i_entry_days,
    input  logic [31:0]                     i_now_seconds,
    input  logic [19:0]                     i_pending_seconds,
    input  logic                            i_snooze_active,
    input  logic                            i_ringing,
    input  logic                            i_on_main_screen,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [19:0]                     i_next_seconds,
    input  logic                            i_auto_off_valid,
    input  logic [2:0]                      i_auto_off_index,
    output int                              o_fail_count,
    output int                              o_outstanding
);

    localparam longint DAY_S    = wan_pkg::DAY_SECONDS;
    localparam longint WEEK_S   = wan_pkg::WEEK_SECONDS;
    localparam longint MINUTE_S = wan_pkg::MINUTE_SECONDS;

    typedef struct packed {
        logic [19:0] next_seconds;
        logic        auto_off_valid;
        logic [2:0]  auto_off_index;
    } t_ring_result;

    logic [2:0]   day_origin;
    logic [11:0]  ring_length;
    logic [10:0]  alarm_minute [ALARM_COUNT];
    logic [7:0]   alarm_days   [ALARM_COUNT];
    t_ring_result expected_rings [$];
    int           fail_count;

    function automatic t_ring_result soonest_ring(input logic [31:0] now,
                                                  input logic [19:0] pend,
                                                  input logic snooze,
                                                  input logic ring,
                                                  input logic main_screen);
        longint       cur;
        longint       best;
        longint       cand;
        longint       pending;
        longint       ring_len;
        longint       mins;
        logic         off_valid;
        logic [2:0]   off_index;
        t_ring_result res;
        cur       = {32'd0, now};
        // fold without a 32-bit wrap
        cur       = (cur + longint'(day_origin) * DAY_S) % WEEK_S;
        pending   = longint'(pend);
        ring_len  = longint'(ring_length);
        best      = 0;
        off_valid = 1'b0;
        off_index = 3'd0;
        for (int i = 0; i < ALARM_COUNT; i++) begin
            if (alarm_days[i][0]) begin
                mins = longint'(alarm_minute[i]) * MINUTE_S;
                if (alarm_days[i] == wan_pkg::ENABLE_BIT) begin
                    cand = mins - cur % DAY_S;
                    if (cand <= 0)
                        cand += DAY_S;
                    // a later one-shot wins a tie
                    if (best == 0 || cand <= best) begin
                        best      = cand;
                        off_valid = main_screen;
                        off_index = 3'(i);
                    end
                end
                for (int k = 0; k < 7; k++) begin
                    if (alarm_days[i][7-k]) begin
                        cand = longint'(k) * DAY_S + mins - cur;
                        if (cand <= 0)
                            cand += WEEK_S;
                        if (best == 0 || cand < best) begin
                            best      = cand;
                            off_valid = 1'b0;
                        end
                    end
                end
            end
        end
        if (snooze && (pending < best || best == 0)) begin
            best      = pending;
            off_valid = 1'b0;
        end
        if (ring) begin
            off_valid = 1'b0;
            if (pending == 0)
                pending = ring_len;
            // extend past the ring still sounding, else hold the countdown
            if (pending >= best && best <= ring_len && best != 0)
                best = best + ring_len;
            else
                best = pending;
        end
        res.next_seconds   = best[19:0];
        res.auto_off_valid = off_valid;
        res.auto_off_index = off_valid ? off_index : 3'd0;
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_ring_result got;
        t_ring_result want;
        if (!i_rst_n) begin
            day_origin  = 3'd0;
            ring_length = wan_pkg::RING_LENGTH_RESET;
            for (int i = 0; i < ALARM_COUNT; i++) begin
                alarm_minute[i] = 11'd0;
                alarm_days[i]   = 8'd0;
            end
            expected_rings.delete();
            fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == wan_pkg::CFG_DAY_ORIGIN)
                    day_origin = i_cfg_data[2:0];
                else if (i_cfg_index == wan_pkg::CFG_RING_LENGTH)
                    ring_length = i_cfg_data;
            end
            // match results before taking this edge's request
            if (i_out_valid && i_out_ready) begin
                got = '{i_next_seconds, i_auto_off_valid, i_auto_off_index};
                if (expected_rings.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result next_seconds %0d auto_off %0b/%0d",
                                 $time, got.next_seconds, got.auto_off_valid,
                                 got.auto_off_index);
                end else begin
                    want = expected_rings.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch exp %0d %0b/%0d got %0d %0b/%0d",
                                     $time, want.next_seconds, want.auto_off_valid,
                                     want.auto_off_index, got.next_seconds,
                                     got.auto_off_valid, got.auto_off_index);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_cmd == wan_pkg::CMD_WRITE) begin
                    if (i_entry_index < ALARM_COUNT) begin
                        alarm_minute[i_entry_index] = i_entry_minute;
                        alarm_days[i_entry_index]   = i_entry_days;
                    end
                end else begin
                    expected_rings.push_back(soonest_ring(i_now_seconds, i_pending_seconds,
                                                          i_snooze_active, i_ringing,
                                                          i_on_main_screen));
                end
            end
        end
        o_fail_count  = fail_count;
        o_outstanding = expected_rings.size();
    end

endmodule

### verif/tb_top.sv
// Testbench top for the weekly alarm next-ring block: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned RUN_LIMIT      = 1_000_000;
    localparam int unsigned DRAIN_CYCLES   = 120;
    localparam int          PHASE_COUNT    = 6;
    localparam int          ITEMS_PER_PHASE = 317;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_HEAVY,
        STALL_BEAT
    } t_stall_mode;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [wan_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [wan_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic                            i_cmd;
    logic [2:0]                      i_entry_index;
    logic [10:0]                     i_entry_minute;
    logic [7:0]                      i_entry_days;
    logic [31:0]                     i_now_seconds;
    logic [19:0]                     i_pending_seconds;
    logic                            i_snooze_active;
    logic                            i_ringing;
    logic                            i_on_main_screen;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic [19:0]                     o_next_seconds;
    logic                            o_auto_off_valid;
    logic [2:0]                      o_auto_off_index;

    int          fail_count;
    int          outstanding_rings;
    int unsigned cycle_count = 0;
    t_stall_mode stall_mode  = STALL_NONE;
    int          stall_left  = 0;
    int          burst_left;
    int          ring_len_now;
    logic [10:0] shadow_minute [8];

    weekly_alarm_next_ring_top #(.ALARM_COUNT(8)) dut (.*);

    wan_ring_checker #(.ALARM_COUNT(8)) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_entry_index     (i_entry_index),
        .i_entry_minute    (i_entry_minute),
        .i_entry_days      (i_entry_days),
        .i_now_seconds     (i_now_seconds),
        .i_pending_seconds (i_pending_seconds),
        .i_snooze_active   (i_snooze_active),
        .i_ringing         (i_ringing),
        .i_on_main_screen  (i_on_main_screen),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_next_seconds    (o_next_seconds),
        .i_auto_off_valid  (o_auto_off_valid),
        .i_auto_off_index  (o_auto_off_index),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding_rings)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: switch between free flow, coin-toss, heavy and beat stalls
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_out_ready <= 1'b1;
            STALL_COIN:  i_out_ready <= 1'($urandom_range(0, 1));
            STALL_HEAVY: i_out_ready <= ($urandom_range(0, 3) == 0);
            default:     i_out_ready <= cycle_count[3];
        endcase
    end

    task automatic put_request(input logic cmd, input logic [2:0] idx,
                               input logic [10:0] minute, input logic [7:0] days,
                               input logic [31:0] now, input logic [19:0] pend,
                               input logic snooze, input logic ring,
                               input logic main_screen);
        int gap;
        i_in_valid        <= 1'b1;
        i_cmd             <= cmd;
        i_entry_index     <= idx;
        i_entry_minute    <= minute;
        i_entry_days      <= days;
        i_now_seconds     <= now;
        i_pending_seconds <= pend;
        i_snooze_active   <= snooze;
        i_ringing         <= ring;
        i_on_main_screen  <= main_screen;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 16);
        end
    endtask

    task automatic write_entry(input logic [2:0] idx, input logic [10:0] minute,
                               input logic [7:0] days);
        shadow_minute[idx] = minute;
        put_request(wan_pkg::CMD_WRITE, idx, minute, days, $urandom, 20'($urandom),
                    1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic compute_ring(input logic [31:0] now, input logic [19:0] pend,
                                input logic snooze, input logic ring,
                                input logic main_screen);
        put_request(wan_pkg::CMD_COMPUTE, 3'($urandom), 11'($urandom), 8'($urandom),
                    now, pend, snooze, ring, main_screen);
    endtask

    task automatic random_request();
        int          pick;
        int          j;
        int          delta;
        longint      when;
        logic [10:0] minute;
        logic [7:0]  days;
        logic [19:0] pend;
        logic [31:0] now;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            minute = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(1440, 2047))
                                                 : 11'($urandom_range(0, 1439));
            pick = $urandom_range(0, 9);
            if (pick < 2)
                days = wan_pkg::ENABLE_BIT;
            else if (pick == 2)
                days = 8'($urandom);
            else
                days = {7'($urandom), 1'b1};
            write_entry(3'($urandom), minute, days);
        end else begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                pend = 20'd0;
            else if (pick < 7)
                pend = 20'($urandom_range(0, ring_len_now * 2 + 2));
            else if (pick < 9)
                pend = 20'($urandom);
            else
                pend = 20'($urandom_range(0, 5000));
            if ($urandom_range(0, 3) == 0) begin
                now = $urandom;
            end else begin
                // land just around a stored alarm so the ring overlap rule is hit
                j     = $urandom_range(0, 7);
                delta = $urandom_range(0, ring_len_now + 60);
                delta = delta - 30;
                when  = longint'($urandom_range(1, 49000)) * wan_pkg::DAY_SECONDS
                        + longint'(shadow_minute[j]) * wan_pkg::MINUTE_SECONDS - delta;
                now   = when[31:0];
            end
            compute_ring(now, pend, ($urandom_range(0, 2) == 0), ($urandom_range(0, 2) == 0),
                         1'($urandom));
        end
    endtask

    task automatic program_regs(input logic [11:0] offset_word, input logic [11:0] ring_word);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= wan_pkg::CFG_DAY_ORIGIN;
        i_cfg_data  <= offset_word;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_index <= wan_pkg::CFG_RING_LENGTH;
        i_cfg_data  <= ring_word;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        // an unused index must leave both registers alone
        i_cfg_index <= 8'($urandom_range(int'(wan_pkg::CFG_RING_LENGTH) + 1, 255));
        i_cfg_data  <= 12'($urandom);
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        ring_len_now = ring_word;
    endtask

    task automatic settle_block();
        if (i_in_valid)
            i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding_rings != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        i_in_valid        = 1'b0;
        i_cmd             = wan_pkg::CMD_WRITE;
        i_entry_index     = '0;
        i_entry_minute    = '0;
        i_entry_days      = '0;
        i_now_seconds     = '0;
        i_pending_seconds = '0;
        i_snooze_active   = 1'b0;
        i_ringing         = 1'b0;
        i_on_main_screen  = 1'b0;
        burst_left        = $urandom_range(1, 16);
        ring_len_now      = wan_pkg::RING_LENGTH_RESET;
        foreach (shadow_minute[i])
            shadow_minute[i] = 11'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: nothing, snooze only, ring only
        compute_ring(32'd0, 20'd0, 1'b0, 1'b0, 1'b0);
        compute_ring(32'hFFFF_FFFF, 20'hF_FFFF, 1'b1, 1'b0, 1'b1);
        compute_ring(32'd1000, 20'd0, 1'b0, 1'b1, 1'b0);
        // one-shot at 08:00, then a tie on the same minute
        write_entry(3'd0, 11'd480, wan_pkg::ENABLE_BIT);
        compute_ring(32'd0, 20'd0, 1'b0, 1'b0, 1'b1);
        compute_ring(32'd28800, 20'd0, 1'b0, 1'b0, 1'b1);
        write_entry(3'd5, 11'd480, wan_pkg::ENABLE_BIT);
        compute_ring(32'd28000, 20'd0, 1'b0, 1'b0, 1'b1);
        compute_ring(32'd28000, 20'd500, 1'b1, 1'b0, 1'b1);
        compute_ring(32'd28770, 20'd100, 1'b0, 1'b1, 1'b1);
        compute_ring(32'd28770, 20'd10, 1'b0, 1'b1, 1'b0);
        // every day, then the same days with the alarm switched off
        write_entry(3'd3, 11'd1439, 8'hFF);
        compute_ring(32'hFFFF_FFFF, 20'd0, 1'b0, 1'b0, 1'b1);
        write_entry(3'd3, 11'd1439, 8'hFE);
        // minutes beyond the day
        write_entry(3'd7, 11'd2047, wan_pkg::ENABLE_BIT);
        compute_ring(32'd86399, 20'd0, 1'b0, 1'b0, 1'b1);
        write_entry(3'd6, 11'd2047, 8'h81);
        compute_ring(32'd0, 20'd0, 1'b0, 1'b0, 1'b1);
        // Saturday midnight reached exactly
        write_entry(3'd2, 11'd0, 8'h03);
        compute_ring(32'd518400, 20'd0, 1'b0, 1'b0, 1'b1);
        write_entry(3'd1, 11'd0, 8'h00);
        write_entry(3'd4, 11'd1439, 8'h55);
        compute_ring(32'd123456789, 20'd0, 1'b1, 1'b1, 1'b1);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase != 0) begin
                settle_block();
                case (phase)
                    1:       program_regs({9'($urandom), 3'd6}, 12'd3600);
                    2:       program_regs({9'($urandom), 3'd7}, 12'd1);
                    3:       program_regs(12'd0, 12'd0);
                    4:       program_regs({9'($urandom), 3'd3}, 12'd4095);
                    default: program_regs(12'($urandom), 12'($urandom));
                endcase
            end
            repeat (ITEMS_PER_PHASE) random_request();
        end

        settle_block();
        if (fail_count == 0 && outstanding_rings == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
